// ===== rtl/spc_pkg.sv =====
package spc_pkg;

  localparam int CHANNEL_COUNT_DEF = 16;
  localparam int TRACKED_COUNT_DEF = 5;
  localparam int VALUE_BITS_DEF    = 25;

  localparam int CH_W       = 4;
  localparam int COUNT_W    = 8;
  localparam int LIMIT_W    = 24;
  localparam int CHANGE_W   = 26;
  localparam int SLOT_W     = 3;
  localparam int NUM_LIMITS = 5;
  localparam int CMP_W      = 34;
  localparam int CFG_IDX_W  = 3;

  localparam logic [SLOT_W-1:0]  NO_SLOT   = 3'd7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STUCK_THRESHOLD = 3'd0,
    REG_JUMP_TEMP       = 3'd1,
    REG_JUMP_HUMIDITY   = 3'd2,
    REG_JUMP_PRESSURE   = 3'd3,
    REG_JUMP_BATTERY    = 3'd4,
    REG_JUMP_SOLAR      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]                   stuck_threshold;
    logic [NUM_LIMITS-1:0][LIMIT_W-1:0]   jump_limit;
  } cfg_t;

  typedef struct packed {
    logic                stuck_flag;
    logic [COUNT_W-1:0]  repeat_count;
    logic                abrupt_change;
    logic [CHANGE_W-1:0] change_amount;
  } hist_res_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [CH_W-1:0] ch);
    logic [SLOT_W-1:0] s;
    case (ch)
      4'd0:    s = 3'd0;
      4'd1:    s = 3'd1;
      4'd2:    s = 3'd2;
      4'd11:   s = 3'd3;
      4'd12:   s = 3'd4;
      default: s = NO_SLOT;
    endcase
    return s;
  endfunction

  function automatic logic signed [CMP_W-1:0] range_lo(input logic [CH_W-1:0] ch);
    logic signed [CMP_W-1:0] r;
    case (ch)
      4'd0:    r = -34'sd4000;
      4'd2:    r = 34'sd30000;
      4'd3:    r = -34'sd50000;
      4'd14:   r = -34'sd500;
      4'd15:   r = -34'sd50;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [CMP_W-1:0] range_hi(input logic [CH_W-1:0] ch);
    logic signed [CMP_W-1:0] r;
    case (ch)
      4'd0:    r = 34'sd8500;
      4'd1:    r = 34'sd10000;
      4'd2:    r = 34'sd110000;
      4'd3:    r = 34'sd900000;
      4'd4:    r = 34'sd330;
      4'd5:    r = 34'sd330;
      4'd6:    r = 34'sd100000;
      4'd7:    r = 34'sd15000;
      4'd8:    r = 34'sd35900;
      4'd9:    r = 34'sd360;
      4'd10:   r = 34'sd550;
      4'd11:   r = 34'sd1500;
      4'd12:   r = 34'sd2500;
      4'd13:   r = 34'sd2500;
      default: r = 34'sd500;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/spc_cfg_regs.sv =====
module spc_cfg_regs
  import spc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stuck_threshold <= 8'd3;
      cfg.jump_limit[0]   <= 24'd500;
      cfg.jump_limit[1]   <= 24'd2000;
      cfg.jump_limit[2]   <= 24'd1000;
      cfg.jump_limit[3]   <= 24'd200;
      cfg.jump_limit[4]   <= 24'd999900;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STUCK_THRESHOLD: cfg.stuck_threshold <= cfg_data[COUNT_W-1:0];
        REG_JUMP_TEMP:       cfg.jump_limit[0]   <= cfg_data;
        REG_JUMP_HUMIDITY:   cfg.jump_limit[1]   <= cfg_data;
        REG_JUMP_PRESSURE:   cfg.jump_limit[2]   <= cfg_data;
        REG_JUMP_BATTERY:    cfg.jump_limit[3]   <= cfg_data;
        REG_JUMP_SOLAR:      cfg.jump_limit[4]   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/spc_history.sv =====
module spc_history
  import spc_pkg::*;
#(
  parameter int TRACKED_COUNT = TRACKED_COUNT_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [CH_W-1:0]              channel,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         present,
  input  cfg_t                         cfg,
  output hist_res_t                    res
);

  logic signed [VALUE_BITS-1:0] previous_value [TRACKED_COUNT];
  logic                         previous_known [TRACKED_COUNT];
  logic [COUNT_W-1:0]           repeat_counter [TRACKED_COUNT];

  logic [SLOT_W-1:0]            slot;
  logic                         tracked;
  logic signed [VALUE_BITS-1:0] prev_sel;
  logic                         known_sel;
  logic [COUNT_W-1:0]           count_sel;
  logic [LIMIT_W-1:0]           limit_sel;
  logic signed [VALUE_BITS:0]   delta;
  logic [VALUE_BITS:0]          mag;
  logic                         same;
  logic [COUNT_W-1:0]           count_next;
  logic                         update;

  assign slot    = slot_of(channel);
  assign tracked = (slot != NO_SLOT) && (CMP_W'(slot) < CMP_W'(TRACKED_COUNT));

  always_comb begin
    prev_sel  = '0;
    known_sel = 1'b0;
    count_sel = '0;
    for (int i = 0; i < TRACKED_COUNT; i++) begin
      if (slot == SLOT_W'(i)) begin
        prev_sel  = previous_value[i];
        known_sel = previous_known[i];
        count_sel = repeat_counter[i];
      end
    end
    limit_sel = '0;
    for (int j = 0; j < NUM_LIMITS; j++) begin
      if (slot == SLOT_W'(j)) begin
        limit_sel = cfg.jump_limit[j];
      end
    end
  end

  assign delta = (VALUE_BITS+1)'(value) - (VALUE_BITS+1)'(prev_sel);
  assign mag   = delta[VALUE_BITS] ? (VALUE_BITS+1)'(-delta) : (VALUE_BITS+1)'(delta);
  assign same  = (value == prev_sel);

  always_comb begin
    if (!known_sel) begin
      count_next = count_sel;
    end else if (same) begin
      count_next = (count_sel == COUNT_MAX) ? count_sel : count_sel + 1'b1;
    end else begin
      count_next = '0;
    end
  end

  assign update = load && present && tracked;

  always_comb begin
    res = '0;
    if (tracked) begin
      res.repeat_count = present ? count_next : count_sel;
      if (present && known_sel) begin
        res.stuck_flag    = same && (count_next >= cfg.stuck_threshold);
        res.abrupt_change = CMP_W'(mag) > CMP_W'(limit_sel);
        res.change_amount = CHANGE_W'(delta);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TRACKED_COUNT; k++) begin
        previous_value[k] <= '0;
        previous_known[k] <= 1'b0;
        repeat_counter[k] <= '0;
      end
    end else if (update) begin
      for (int k = 0; k < TRACKED_COUNT; k++) begin
        if (slot == SLOT_W'(k)) begin
          previous_value[k] <= value;
          previous_known[k] <= 1'b1;
          repeat_counter[k] <= count_next;
        end
      end
    end
  end

endmodule

// ===== rtl/sensor_plausibility_checker_unit.sv =====
// A sample is held in the input register until the result register can take it; its
//   result is then registered there and raises out_valid.
// Throughput: one sample per cycle unless stalled; one input register, one result
//   register, with the per-channel history read and written between them in the same cycle.
// Reset (rst, synchronous, active high): empties both registers, restores register
//   defaults and clears the history of every tracked channel.
module sensor_plausibility_checker_unit
  import spc_pkg::*;
#(
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
  parameter int TRACKED_COUNT = TRACKED_COUNT_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [LIMIT_W-1:0]           cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [CH_W-1:0]              channel,
  input  logic signed [VALUE_BITS-1:0] sample_value,
  input  logic                         sample_present,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CH_W-1:0]              channel_echo,
  output logic                         out_of_range,
  output logic                         stuck_flag,
  output logic [COUNT_W-1:0]           repeat_count,
  output logic                         abrupt_change,
  output logic signed [CHANGE_W-1:0]   change_amount
);

  cfg_t      cfg;
  hist_res_t hres;

  logic                         item_valid;
  logic [CH_W-1:0]              item_channel;
  logic signed [VALUE_BITS-1:0] item_value;
  logic                         item_present;
  logic                         advance;
  logic                         range_bad;

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  spc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spc_history #(
    .TRACKED_COUNT (TRACKED_COUNT),
    .VALUE_BITS    (VALUE_BITS)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .load    (advance),
    .channel (item_channel),
    .value   (item_value),
    .present (item_present),
    .cfg     (cfg),
    .res     (hres)
  );

  assign range_bad = item_present
                  && ((CH_W+1)'(item_channel) < (CH_W+1)'(CHANNEL_COUNT))
                  && ((CMP_W'(item_value) < range_lo(item_channel))
                   || (CMP_W'(item_value) > range_hi(item_channel)));

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_channel <= channel;
      item_value   <= sample_value;
      item_present <= sample_present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      channel_echo  <= item_channel;
      out_of_range  <= range_bad;
      stuck_flag    <= hres.stuck_flag;
      repeat_count  <= hres.repeat_count;
      abrupt_change <= hres.abrupt_change;
      change_amount <= hres.change_amount;
    end
  end

endmodule

// ===== rtl/spc_checker.sv =====
module spc_checker
  import spc_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [CH_W-1:0]              channel_echo,
  input logic                         stuck_flag,
  input logic [COUNT_W-1:0]           repeat_count,
  input logic                         abrupt_change,
  input logic signed [CHANGE_W-1:0]   change_amount
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(channel_echo))
    else $error("stalled result dropped or changed");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register is empty");

  a_stuck_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && stuck_flag |-> change_amount == '0 && repeat_count != '0 && !abrupt_change)
    else $error("stuck result with nonzero change or zero count");

  a_abrupt_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && abrupt_change |-> change_amount != '0 && !stuck_flag)
    else $error("abrupt result with zero change");

endmodule

bind sensor_plausibility_checker_unit spc_checker u_spc_checker (.*);

// ===== test/sensor_plausibility_checker_unit_tb.sv =====
`timescale 1ns / 1ps

module sensor_plausibility_checker_unit_tb;
  import spc_pkg::*;

  localparam int LATENCY = 2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint VALUE_MAX = 2**(VALUE_BITS_DEF-1) - 1;
  localparam longint VALUE_MIN = -(2**(VALUE_BITS_DEF-1));
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic                oor;
    logic                stuck;
    logic [COUNT_W-1:0]  cnt;
    logic                abrupt;
    logic [CHANGE_W-1:0] change;
  } verdict_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [CH_W-1:0] channel;
  logic signed [VALUE_BITS_DEF-1:0] sample_value;
  logic sample_present;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_W-1:0] channel_echo;
  logic out_of_range;
  logic stuck_flag;
  logic [COUNT_W-1:0] repeat_count;
  logic abrupt_change;
  logic signed [CHANGE_W-1:0] change_amount;

  int low_limit [16] = '{-4000, 0, 30000, -50000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, -500, -50};
  int high_limit [16] = '{8500, 10000, 110000, 900000, 330, 330, 100000, 15000, 35900,
                          360, 550, 1500, 2500, 2500, 500, 500};
  int tracked_slot [16] = '{0, 1, 2, -1, -1, -1, -1, -1, -1, -1, -1, 3, 4, -1, -1, -1};
  int tracked_ch [5] = '{0, 1, 2, 11, 12};

  logic [COUNT_W-1:0] threshold_cfg;
  logic [LIMIT_W-1:0] jump_cfg [5];
  logic signed [VALUE_BITS_DEF-1:0] last_value [5];
  bit last_known [5];
  logic [COUNT_W-1:0] repeat_cnt [5];

  verdict_t pending_verdicts [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_count = 0;
  int oor_seen = 0;
  int stuck_seen = 0;
  int abrupt_seen = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  sensor_plausibility_checker_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .channel        (channel),
    .sample_value   (sample_value),
    .sample_present (sample_present),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .channel_echo   (channel_echo),
    .out_of_range   (out_of_range),
    .stuck_flag     (stuck_flag),
    .repeat_count   (repeat_count),
    .abrupt_change  (abrupt_change),
    .change_amount  (change_amount)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic verdict_t judge_sample(input logic [CH_W-1:0] ch,
                                            input logic signed [VALUE_BITS_DEF-1:0] val,
                                            input bit present);
    verdict_t r;
    int slot;
    longint delta;
    longint mag;
    r = '0;
    r.ch = ch;
    slot = tracked_slot[ch];
    if (present) begin
      r.oor = (longint'(val) < longint'(low_limit[ch])) ||
              (longint'(val) > longint'(high_limit[ch]));
      if (slot >= 0) begin
        if (last_known[slot]) begin
          delta = longint'(val) - longint'(last_value[slot]);
          mag = (delta < 0) ? -delta : delta;
          if (delta == 0) begin
            if (repeat_cnt[slot] != COUNT_MAX) repeat_cnt[slot] = repeat_cnt[slot] + 1'b1;
            if (repeat_cnt[slot] >= threshold_cfg) r.stuck = 1'b1;
          end else begin
            repeat_cnt[slot] = '0;
          end
          r.abrupt = mag > longint'(jump_cfg[slot]);
          r.change = delta[CHANGE_W-1:0];
        end
        last_value[slot] = val;
        last_known[slot] = 1'b1;
      end
    end
    if (slot >= 0) r.cnt = repeat_cnt[slot];
    return r;
  endfunction

  function automatic longint pick_value(input logic [CH_W-1:0] ch);
    longint v;
    case ($urandom_range(0, 9))
      0: v = longint'($signed($urandom_range(0, 2**VALUE_BITS_DEF - 1)));
      1: v = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
      2, 3: v = longint'(low_limit[ch]) + int'($urandom_range(0, 2)) - 1;
      4, 5: v = longint'(high_limit[ch]) + int'($urandom_range(0, 2)) - 1;
      default: v = longint'(low_limit[ch]) +
                   longint'($urandom_range(0, high_limit[ch] - low_limit[ch]));
    endcase
    return v;
  endfunction

  task automatic reset_model();
    threshold_cfg = 8'd3;
    jump_cfg[0] = 24'd500;
    jump_cfg[1] = 24'd2000;
    jump_cfg[2] = 24'd1000;
    jump_cfg[3] = 24'd200;
    jump_cfg[4] = 24'd999900;
    for (int i = 0; i < 5; i++) begin
      last_value[i] = '0;
      last_known[i] = 1'b0;
      repeat_cnt[i] = '0;
    end
  endtask

  task automatic send_sample(input logic [CH_W-1:0] ch, input longint val, input bit present);
    int gap;
    gap = in_gaps_on ? idle_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    sample_value <= val[VALUE_BITS_DEF-1:0];
    sample_present <= present;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_verdicts.push_back(judge_sample(ch, val[VALUE_BITS_DEF-1:0], present));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_STUCK_THRESHOLD: threshold_cfg = data[COUNT_W-1:0];
      REG_JUMP_TEMP:       jump_cfg[0] = data;
      REG_JUMP_HUMIDITY:   jump_cfg[1] = data;
      REG_JUMP_PRESSURE:   jump_cfg[2] = data;
      REG_JUMP_BATTERY:    jump_cfg[3] = data;
      REG_JUMP_SOLAR:      jump_cfg[4] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(input logic [COUNT_W-1:0] thr,
                              input logic [LIMIT_W-1:0] temp, input logic [LIMIT_W-1:0] hum,
                              input logic [LIMIT_W-1:0] press, input logic [LIMIT_W-1:0] batt,
                              input logic [LIMIT_W-1:0] solar);
    wait_idle();
    write_reg(REG_STUCK_THRESHOLD, LIMIT_W'(thr));
    write_reg(REG_JUMP_TEMP, temp);
    write_reg(REG_JUMP_HUMIDITY, hum);
    write_reg(REG_JUMP_PRESSURE, press);
    write_reg(REG_JUMP_BATTERY, batt);
    write_reg(REG_JUMP_SOLAR, solar);
    settings_count++;
  endtask

  task automatic test_defaults_directed();
    send_sample(0, 2000, 1'b1);
    repeat (3) send_sample(0, 2000, 1'b1);
    send_sample(0, -9999, 1'b0);
    send_sample(0, 2600, 1'b1);
    send_sample(0, 3100, 1'b1);
    send_sample(0, -4001, 1'b1);
    send_sample(0, 8501, 1'b1);
    send_sample(1, -1, 1'b1);
    send_sample(2, VALUE_MAX, 1'b1);
    send_sample(2, VALUE_MIN, 1'b1);
    send_sample(11, 1501, 1'b1);
    send_sample(12, 2500, 1'b1);
    send_sample(3, -50000, 1'b1);
    send_sample(3, 900001, 1'b1);
    send_sample(8, 35901, 1'b1);
    send_sample(14, -501, 1'b1);
    send_sample(15, -50, 1'b1);
    send_sample(13, VALUE_MIN, 1'b0);
    send_sample(6, 100000, 1'b1);
    send_sample(9, 361, 1'b1);
    send_sample(4, 0, 1'b1);
  endtask

  task automatic test_stuck_threshold_extremes();
    wait_idle();
    write_reg(REG_STUCK_THRESHOLD, '0);
    send_sample(12, 1000, 1'b1);
    send_sample(12, 1000, 1'b1);
    send_sample(12, 1005, 1'b1);
    send_sample(12, 1005, 1'b0);
    send_sample(12, 1005, 1'b1);
    wait_idle();
    write_reg(REG_STUCK_THRESHOLD, LIMIT_W'(COUNT_MAX));
    // drive the counter into saturation
    repeat (260) send_sample(11, 777, 1'b1);
    send_sample(11, 777, 1'b0);
    send_sample(11, 778, 1'b1);
  endtask

  task automatic test_jump_limit_extremes();
    apply_config(8'd3, '0, '0, '0, '0, '0);
    send_sample(0, 100, 1'b1);
    send_sample(0, 100, 1'b1);
    send_sample(0, 101, 1'b1);
    send_sample(1, 50, 1'b1);
    send_sample(1, 51, 1'b1);
    apply_config(8'd3, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
    send_sample(2, VALUE_MIN, 1'b1);
    send_sample(2, VALUE_MAX, 1'b1);
    send_sample(2, VALUE_MAX - longint'(LIMIT_MAX), 1'b1);
    send_sample(2, VALUE_MAX - 2 * longint'(LIMIT_MAX) - 1, 1'b1);
    wait_idle();
    // indexes past the last register must not disturb anything
    for (int i = REG_JUMP_SOLAR + 1; i < 2**CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), LIMIT_W'($urandom));
    send_sample(11, 0, 1'b1);
    send_sample(11, 1500, 1'b1);
  endtask

  task automatic test_random_phase(input int n_items, input bit gaps, input bit stalls);
    int sent;
    int len;
    int slot;
    logic [CH_W-1:0] ch;
    longint v;
    longint step;
    bit present;
    in_gaps_on = gaps;
    out_stalls_on = stalls;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) != 0) ch = CH_W'(tracked_ch[$urandom_range(0, 4)]);
      else ch = CH_W'($urandom_range(0, 15));
      slot = tracked_slot[ch];
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      v = pick_value(ch);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 4))
          0, 1: ;
          2: begin
            step = (slot >= 0) ? longint'(jump_cfg[slot]) : 100;
            step = step + int'($urandom_range(0, 2)) - 1;
            v = $urandom_range(0, 1) ? v + step : v - step;
          end
          3: v = pick_value(ch);
          default: v = v + int'($urandom_range(0, 6)) - 3;
        endcase
        present = $urandom_range(0, 9) != 0;
        send_sample(ch, v, present);
      end
      sent += len;
      // hold the sender until every result is back
      if ($urandom_range(0, 59) == 0) wait_idle();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0 && out_stalls_on) stall_left = idle_length();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("result transaction with no sample waiting");
        mismatch_count++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (exp_v.oor) oor_seen++;
        if (exp_v.stuck) stuck_seen++;
        if (exp_v.abrupt) abrupt_seen++;
        if (channel_echo !== exp_v.ch) begin
          $error("channel_echo: expected %0d, actual %0d", exp_v.ch, channel_echo);
          mismatch_count++;
        end
        if (out_of_range !== exp_v.oor) begin
          $error("out_of_range: expected %0d, actual %0d", exp_v.oor, out_of_range);
          mismatch_count++;
        end
        if (stuck_flag !== exp_v.stuck) begin
          $error("stuck_flag: expected %0d, actual %0d", exp_v.stuck, stuck_flag);
          mismatch_count++;
        end
        if (repeat_count !== exp_v.cnt) begin
          $error("repeat_count: expected %0d, actual %0d", exp_v.cnt, repeat_count);
          mismatch_count++;
        end
        if (abrupt_change !== exp_v.abrupt) begin
          $error("abrupt_change: expected %0d, actual %0d", exp_v.abrupt, abrupt_change);
          mismatch_count++;
        end
        if (change_amount !== exp_v.change) begin
          $error("change_amount: expected %0d, actual %0d",
                 $signed(exp_v.change), change_amount);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    channel = '0;
    sample_value = '0;
    sample_present = 1'b0;
    reset_model();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_defaults_directed();
    test_stuck_threshold_extremes();
    test_jump_limit_extremes();
    apply_config(8'd3, 24'd500, 24'd2000, 24'd1000, 24'd200, 24'd999900);
    test_random_phase(380, 1'b1, 1'b1);
    apply_config(8'd1, '0, '0, '0, '0, '0);
    test_random_phase(360, 1'b0, 1'b0);
    apply_config(COUNT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
    test_random_phase(360, 1'b1, 1'b1);
    apply_config(COUNT_W'($urandom_range(1, 6)), LIMIT_W'($urandom_range(0, 3000)),
                 LIMIT_W'($urandom_range(0, 3000)), LIMIT_W'($urandom_range(0, 3000)),
                 LIMIT_W'($urandom_range(0, 3000)), LIMIT_W'($urandom_range(0, 3000)));
    test_random_phase(360, 1'b1, 1'b0);
    apply_config(COUNT_W'($urandom_range(0, 255)), LIMIT_W'($urandom),
                 LIMIT_W'($urandom), LIMIT_W'($urandom), LIMIT_W'($urandom),
                 LIMIT_W'($urandom));
    test_random_phase(360, 1'b0, 1'b1);

    wait_idle();
    $display("Run covered %0d samples on all channels under %0d register settings.",
             items_sent, settings_count);
    $display("Results checked: %0d (out of range %0d, stuck %0d, abrupt %0d).",
             results_seen, oor_seen, stuck_seen, abrupt_seen);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spc_pkg.sv
rtl/spc_cfg_regs.sv
rtl/spc_history.sv
rtl/sensor_plausibility_checker_unit.sv
rtl/spc_checker.sv
test/sensor_plausibility_checker_unit_tb.sv
